// ===== rtl/two_stack_text_buffer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-stack text buffer
// Concurrent checks that vanish when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_STACK_TEXT_BUFFER_MACROS_SVH
`define TWO_STACK_TEXT_BUFFER_MACROS_SVH

`ifndef SYNTH
`define TSTB_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("tstb assertion failed");
`define TSTB_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tstb assertion failed");
`define TSTB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tstb assertion failed");
`else
`define TSTB_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define TSTB_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define TSTB_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/tstb_pkg.sv =====
// ----------------------------------------------------------------------------
// tstb_pkg
// Shared types and codes of the two-stack text buffer.
// ----------------------------------------------------------------------------
package tstb_pkg;

   localparam int CHAR_W = 8;
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_DELETE  = 3'd1,
      OP_LEFT    = 3'd2,
      OP_RIGHT   = 3'd3,
      OP_DISPLAY = 3'd4
   } tstb_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } tstb_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DISP
   } tstb_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;     // latch the command and issue its first store read
      logic do_edit;  // finish an edit command and load its result
      logic do_disp;  // emit one displayed character
   } tstb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic legal;      // incoming op code is a defined command
      logic disp_busy;  // incoming op is a display of non-empty text
      logic disp_last;  // the current display character is the final one
      logic out_free;   // the result register can be loaded this cycle
   } tstb_stat_type;

endpackage

// ===== rtl/tstb_req_if.sv =====
// ----------------------------------------------------------------------------
// tstb_req_if
// Command channel: op code and character with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tstb_req_if;
   logic                          valid;
   logic                          ready;
   logic [tstb_pkg::OP_W-1:0]     op;
   logic [tstb_pkg::CHAR_W-1:0]   char_in;

   modport source (output valid, output op, output char_in, input ready);
   modport sink   (input valid, input op, input char_in, output ready);
endinterface

// ===== rtl/tstb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tstb_rsp_if
// Result channel: status, character and framing with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tstb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tstb_pkg::STATUS_W-1:0] status;
   logic [tstb_pkg::CHAR_W-1:0]   char_out;
   logic                          is_text;
   logic                          last;

   modport source (output valid, output status, output char_out, output is_text,
                   output last, input ready);
   modport sink   (input valid, input status, input char_out, input is_text,
                   input last, output ready);
endinterface

// ===== rtl/two_stack_text_buffer.sv =====
// ----------------------------------------------------------------------------
// two_stack_text_buffer
// Line of text with a cursor, held as a gap buffer in one byte store.
// ----------------------------------------------------------------------------
// Use of the block:
// Commands arrive on req_chan (op, char_in) and results leave on rsp_chan
// (status, char_out, is_text, last); each channel moves a transfer when valid
// and ready are both high. Insert, delete, cursor left and cursor right give
// one status result each; display gives one result per character in text
// order, marked last on the final one, or a single non-text result when the
// text is empty. Undefined op codes are taken and give no result.
// An edit result is loaded into the result register from the EXEC state
// after its command transfer. A display reads its first character at the
// transfer, loads it from the DISP state and then emits one character per
// cycle while the receiver is ready; the single read port of the text
// store sets that pace. A new command is taken once the current one has
// loaded its last result, even while that result waits in the output
// register. If the receiver stalls, the result register holds and the block
// waits with it. Reset empties the text and clears the output valid flag;
// the store contents are not cleared, as only written entries are used.
// ----------------------------------------------------------------------------
module two_stack_text_buffer #(
   parameter int CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   tstb_req_if.sink    req_chan,
   tstb_rsp_if.source  rsp_chan
);

   // Command and status groups between the sequencer and the datapath.
   tstb_pkg::tstb_cmd_type  cmd;
   tstb_pkg::tstb_stat_type stat;

   // The sequencer owns the request handshake: it is ready only between
   // commands, and it paces each command by the state of the result register.
   tstb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds both stack counts, the text store and the result
   // register that drives the response channel.
   tstb_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_op       (req_chan.op),
      .req_char_in  (req_chan.char_in),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_status   (rsp_chan.status),
      .rsp_char_out (rsp_chan.char_out),
      .rsp_is_text  (rsp_chan.is_text),
      .rsp_last     (rsp_chan.last)
   );

endmodule

// ===== rtl/tstb_ram.sv =====
// ----------------------------------------------------------------------------
// tstb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tstb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tstb_datapath.sv =====
// ----------------------------------------------------------------------------
// tstb_datapath
// Stack counters, text store and result register of the text buffer.
// ----------------------------------------------------------------------------
`include "two_stack_text_buffer_macros.svh"

module tstb_datapath #(
   parameter int CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tstb_pkg::OP_W-1:0]         req_op,
   input  logic [tstb_pkg::CHAR_W-1:0]       req_char_in,
   input  tstb_pkg::tstb_cmd_type            cmd,
   output tstb_pkg::tstb_stat_type           stat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tstb_pkg::STATUS_W-1:0]     rsp_status,
   output logic [tstb_pkg::CHAR_W-1:0]       rsp_char_out,
   output logic                              rsp_is_text,
   output logic                              rsp_last
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] right_ff, right_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [tstb_pkg::OP_W-1:0]   op_ff, op_in;
   logic [tstb_pkg::CHAR_W-1:0] char_ff, char_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   tstb_pkg::tstb_status_type     rsp_status_ff, rsp_status_in;
   logic [tstb_pkg::CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                          rsp_is_text_ff, rsp_is_text_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          load;

   logic [CW:0]   total;
   logic [CW-1:0] gap;
   logic [CW-1:0] left_dec;
   logic [CW-1:0] right_src;
   logic [CW-1:0] right_dst;
   logic [CW-1:0] idx_next;
   logic          full;
   logic          disp_last;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [tstb_pkg::CHAR_W-1:0] wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [tstb_pkg::CHAR_W-1:0] rd_data;

   // Store address of the i-th character of the text: left stack first,
   // then the right stack beyond the gap.
   function automatic logic [AW-1:0] src_addr(input logic [CW-1:0] i,
                                              input logic [CW-1:0] lcnt,
                                              input logic [CW-1:0] gsize);
      logic [CW-1:0] sum;
      sum = i + gsize;
      if (i < lcnt) begin
         return i[AW-1:0];
      end
      return sum[AW-1:0];
   endfunction

   assign total     = {1'b0, left_ff} + {1'b0, right_ff};
   assign gap       = CAP_C - total[CW-1:0];
   assign full      = (total >= {1'b0, CAP_C});
   assign left_dec  = left_ff - CW'(1);
   assign right_src = CAP_C - right_ff;
   assign right_dst = CAP_C - right_ff - CW'(1);
   assign idx_next  = idx_ff + CW'(1);
   assign disp_last = (idx_next == total[CW-1:0]);

   always_comb begin
      stat.legal = req_op inside {tstb_pkg::OP_INSERT, tstb_pkg::OP_DELETE,
                                  tstb_pkg::OP_LEFT, tstb_pkg::OP_RIGHT,
                                  tstb_pkg::OP_DISPLAY};
      stat.disp_busy = (req_op == tstb_pkg::OP_DISPLAY) && (total != '0);
      stat.disp_last = disp_last;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      left_in        = left_ff;
      right_in       = right_ff;
      idx_in         = idx_ff;
      op_in          = op_ff;
      char_in        = char_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = rd_data;
      rd_en          = 1'b0;
      rd_addr        = '0;
      load           = 1'b0;
      rsp_status_in  = tstb_pkg::ST_OK;
      rsp_char_in    = '0;
      rsp_is_text_in = 1'b0;
      rsp_last_in    = 1'b1;

      if (cmd.take) begin
         op_in   = req_op;
         char_in = req_char_in;
         idx_in  = '0;
         rd_en   = 1'b1;
         case (req_op)
            tstb_pkg::OP_LEFT: begin
               rd_addr = left_dec[AW-1:0];
            end
            tstb_pkg::OP_RIGHT: begin
               rd_addr = right_src[AW-1:0];
            end
            tstb_pkg::OP_DISPLAY: begin
               rd_addr = src_addr('0, left_ff, gap);
            end
            default: begin
               rd_addr = '0;
            end
         endcase
      end

      if (cmd.do_edit) begin
         load = 1'b1;
         case (op_ff)
            tstb_pkg::OP_INSERT: begin
               if (full) begin
                  rsp_status_in = tstb_pkg::ST_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = left_ff[AW-1:0];
                  wr_data = char_ff;
                  left_in = left_ff + CW'(1);
               end
            end
            tstb_pkg::OP_DELETE: begin
               if (left_ff == '0) begin
                  rsp_status_in = tstb_pkg::ST_EMPTY;
               end else begin
                  left_in = left_dec;
               end
            end
            tstb_pkg::OP_LEFT: begin
               if (left_ff == '0) begin
                  rsp_status_in = tstb_pkg::ST_EMPTY;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = right_dst[AW-1:0];
                  left_in  = left_dec;
                  right_in = right_ff + CW'(1);
               end
            end
            tstb_pkg::OP_RIGHT: begin
               if (right_ff == '0) begin
                  rsp_status_in = tstb_pkg::ST_EMPTY;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = left_ff[AW-1:0];
                  left_in  = left_ff + CW'(1);
                  right_in = right_ff - CW'(1);
               end
            end
            default: begin
               // Display of an empty text: one plain result.
               rsp_status_in = tstb_pkg::ST_OK;
            end
         endcase
      end

      if (cmd.do_disp) begin
         load           = 1'b1;
         rsp_char_in    = rd_data;
         rsp_is_text_in = 1'b1;
         rsp_last_in    = disp_last;
         // Characters of the right stack are copied down into place as they
         // pass, which leaves the cursor at the end of the text.
         if (idx_ff >= left_ff) begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
         end
         idx_in = idx_next;
         if (disp_last) begin
            left_in  = total[CW-1:0];
            right_in = '0;
         end else begin
            rd_en   = 1'b1;
            rd_addr = src_addr(idx_next, left_ff, gap);
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      op_ff   <= op_in;
      char_ff <= char_in;
      if (load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_char_ff    <= rsp_char_in;
         rsp_is_text_ff <= rsp_is_text_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   tstb_ram #(
      .WIDTH (tstb_pkg::CHAR_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_is_text  = rsp_is_text_ff;
   assign rsp_last     = rsp_last_ff;

   `TSTB_ASSERT_ALWAYS(a_counts_fit, clock, reset, total <= {1'b0, CAP_C})
   `TSTB_ASSERT_NEXT(a_disp_emits, clock, reset, cmd.do_disp, rsp_valid_ff && rsp_is_text_ff)
   `TSTB_ASSERT_NEXT(a_disp_ends_at_end, clock, reset, cmd.do_disp && disp_last, right_ff == '0)

endmodule

// ===== rtl/tstb_ctrl.sv =====
// ----------------------------------------------------------------------------
// tstb_ctrl
// Command sequencer of the text buffer.
// ----------------------------------------------------------------------------
`include "two_stack_text_buffer_macros.svh"

module tstb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tstb_pkg::tstb_stat_type stat,
   output tstb_pkg::tstb_cmd_type  cmd
);

   tstb_pkg::tstb_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tstb_pkg::S_IDLE: begin
            if (req_valid && stat.legal) begin
               state_in = stat.disp_busy ? tstb_pkg::S_DISP : tstb_pkg::S_EXEC;
            end
         end
         tstb_pkg::S_EXEC: begin
            if (stat.out_free) begin
               state_in = tstb_pkg::S_IDLE;
            end
         end
         tstb_pkg::S_DISP: begin
            if (stat.out_free && stat.disp_last) begin
               state_in = tstb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tstb_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.take    = 1'b0;
      cmd.do_edit = 1'b0;
      cmd.do_disp = 1'b0;
      case (state_ff)
         tstb_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         tstb_pkg::S_EXEC: begin
            cmd.do_edit = stat.out_free;
         end
         tstb_pkg::S_DISP: begin
            cmd.do_disp = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tstb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `TSTB_ASSERT_ALWAYS(a_one_cmd, clock, reset, $onehot0({cmd.take, cmd.do_edit, cmd.do_disp}))
   `TSTB_ASSERT_NEXT(a_disp_holds, clock, reset, (state_ff == tstb_pkg::S_DISP) && !stat.out_free, state_ff == tstb_pkg::S_DISP)

endmodule
